/* hw/rtl/msrs_pkg.sv */
// Package for the month/id ordered record store.
// Holds the transaction structs, operation and status codes, and the
// record entry type. No dependencies.
`default_nettype none

package msrs_pkg;

    localparam int MONTH_W = 4;
    localparam int ID_W    = 31;
    localparam int TAG_W   = 16;
    localparam int RANK_W  = 10;
    localparam int COUNT_W = 11;
    localparam int KEY_W   = MONTH_W + ID_W;

    // Operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [MONTH_W-1:0] month;
        logic [ID_W-1:0]    record_id;
        logic [TAG_W-1:0]   tag;
        logic [RANK_W-1:0]  rank;
    } cmd_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [MONTH_W-1:0]  out_month;
        logic [ID_W-1:0]     out_id;
        logic [TAG_W-1:0]    out_tag;
        logic [COUNT_W-1:0]  stored_count;
    } result_t;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [ID_W-1:0]    record_id;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* hw/rtl/msrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/msrs_cmp.sv */
// Shared key compare unit: true when the stored entry sorts at or before
// the new entry (month first, then id). Depends on msrs_pkg.
`default_nettype none

module msrs_cmp (
    input  wire msrs_pkg::entry_t stored,
    input  wire msrs_pkg::entry_t fresh,
    output logic                  le
);
    import msrs_pkg::*;

    logic [KEY_W-1:0] stored_key;
    logic [KEY_W-1:0] fresh_key;

    // Month is the high part of the key, so one unsigned compare covers both
    assign stored_key = {stored.month, stored.record_id};
    assign fresh_key  = {fresh.month, fresh.record_id};
    assign le         = (stored_key <= fresh_key);

endmodule

`default_nettype wire

/* hw/rtl/month_id_stable_sort_rank_select_unit.sv */
// Top level of the month/id ordered record store with rank select.
// Depends on msrs_pkg, msrs_ram and msrs_cmp.
//
// The store keeps its records in stable sorted order (month, then id, ties in
// load order) in one RAM of DEPTH entries, so a fetch reads rank r directly.
// A transaction is taken when start is high and busy is low; its result shows
// on result for exactly one cycle with done high, registered in the cycle
// after the work ends, and the receiver cannot stall it. Clear, the unused
// code, a load into a full store and a fetch out of range finish at once,
// without going busy. A fetch in range passes through S_FRD and S_FOUT. A
// load walks down from the top of the store through the single RAM read port
// and the shared key comparator: S_RD reads a record, S_CMP moves it up one
// slot or, if it sorts at or before the new record, writes the new one above
// it; if none does, or the store is empty, S_WR_NEW puts the new record in
// slot zero. The RAM needs no clearing pass after reset.
`default_nettype none

module month_id_stable_sort_rank_select_unit #(
    parameter int DEPTH = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire msrs_pkg::cmd_t   cmd,
    output logic                  busy,
    output logic                  done,
    output msrs_pkg::result_t     result
);
    import msrs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > RANK_W) ? CW : RANK_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_WR_NEW = 3'd3;
    localparam logic [2:0] S_FRD    = 3'd4;
    localparam logic [2:0] S_FOUT   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] k_reg, k_next;
    entry_t        new_reg, new_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t        rd_entry;
    logic          key_le;

    logic          accept;
    logic          store_full;
    logic          rank_bad;
    entry_t        cmd_entry;

    assign accept     = start && !busy;
    assign store_full = (count_reg == CW'(DEPTH));
    assign rank_bad   = (MW'(cmd.rank) >= MW'(count_reg));
    assign cmd_entry  = '{month: cmd.month, record_id: cmd.record_id, tag: cmd.tag};
    assign rd_entry   = entry_t'(ram_rdata);

    msrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    msrs_cmp u_cmp (
        .stored (rd_entry),
        .fresh  (new_reg),
        .le     (key_le)
    );

    // Sequencer: accept, walk the store for a load, read for a fetch
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        new_next    = new_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = k_reg;
        ram_wdata   = new_reg;
        ram_re      = 1'b0;
        ram_raddr   = k_reg - AW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next = '0;
                    case (cmd.operation)
                        OP_LOAD:
                        begin
                            if (store_full)
                            begin
                                result_next.status       = ST_FULL;
                                result_next.stored_count = COUNT_W'(count_reg);
                                done_next                = 1'b1;
                            end
                            else
                            begin
                                new_next   = cmd_entry;
                                k_next     = AW'(count_reg);
                                state_next = (count_reg == '0) ? S_WR_NEW : S_RD;
                            end
                        end
                        OP_FETCH:
                        begin
                            if (rank_bad)
                            begin
                                result_next.status       = ST_RANGE;
                                result_next.stored_count = COUNT_W'(count_reg);
                                done_next                = 1'b1;
                            end
                            else
                            begin
                                k_next     = AW'(cmd.rank);
                                state_next = S_FRD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            result_next.stored_count = COUNT_W'(count_reg);
                            done_next                = 1'b1;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                // Read the entry just below the current hole
                ram_re     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                ram_we = 1'b1;
                if (key_le)
                begin
                    // New record goes right above this entry
                    ram_wdata                = new_reg;
                    count_next               = count_reg + CW'(1);
                    result_next              = '0;
                    result_next.stored_count = COUNT_W'(count_reg + CW'(1));
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
                else
                begin
                    // Move the entry up one slot and advance the hole down
                    ram_wdata  = rd_entry;
                    k_next     = k_reg - AW'(1);
                    state_next = (k_reg == AW'(1)) ? S_WR_NEW : S_RD;
                end
            end
            S_WR_NEW:
            begin
                ram_we                   = 1'b1;
                ram_wdata                = new_reg;
                count_next               = count_reg + CW'(1);
                result_next              = '0;
                result_next.stored_count = COUNT_W'(count_reg + CW'(1));
                done_next                = 1'b1;
                state_next               = S_IDLE;
            end
            S_FRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = k_reg;
                state_next = S_FOUT;
            end
            S_FOUT:
            begin
                result_next              = '0;
                result_next.out_month    = rd_entry.month;
                result_next.out_id       = rd_entry.record_id;
                result_next.out_tag      = rd_entry.tag;
                result_next.stored_count = COUNT_W'(count_reg);
                done_next                = 1'b1;
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        new_reg    <= new_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Store never holds more than DEPTH records
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("record count above DEPTH");

    // Hole index is above zero whenever an entry below it is read or compared
    a_hole_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_CMP) |-> (k_reg != '0))
        else $error("insert walk below slot zero");

    // A result appears only once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while busy");

    // RAM is written only during a load walk
    a_write_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CMP || state_reg == S_WR_NEW))
        else $error("store write outside a load");

    // A load finished in S_WR_NEW grows the count by one
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR_NEW) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("load did not advance count");

endmodule

`default_nettype wire
